>>> src/gspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspl_pkg: shared types and tables for the gas sensor ppm linearizer
// Payload structs, fixed-point widths, compensation table, ppm curve and the
// reciprocal constants used in place of dividers.
// ----------------------------------------------------------------------------
package gspl_pkg;

	localparam int CURVE_POINTS = 19;
	localparam int TEMP_POINTS  = 6;
	localparam int HUMI_POINTS  = 5;

	localparam int TI_W = $clog2(TEMP_POINTS);
	localparam int HI_W = $clog2(HUMI_POINTS);
	localparam int HC_W = $clog2(HUMI_POINTS - 1);
	localparam int CK_W = $clog2(CURVE_POINTS);

	localparam int VOLT_W       = 14;
	localparam int TW_W         = 4;
	localparam int HW_W         = 6;
	localparam int RATIO_W      = 17;
	localparam int A_W          = 21;
	localparam int VR_W         = 34;
	localparam int N_W          = 33;
	localparam int NUM_W        = 26;
	localparam int RSHIFT       = 36;
	localparam int DEN_RECIP_W  = 29;
	localparam int DP_W         = NUM_W + DEN_RECIP_W;
	localparam int D_W          = 51;
	localparam int QPRE         = 12;
	localparam int N2_W         = N_W + QPRE;
	localparam int QUO_W        = 20;
	localparam int SPAN_W       = 13;
	localparam int X_W          = 23;
	localparam int SPAN_RECIP_W = 27;
	localparam int SP_W         = X_W + SPAN_RECIP_W;
	localparam int PPM_W        = 14;
	localparam int FLAG_W       = 6;

	localparam int FLAG_BELOW  = 0;
	localparam int FLAG_ABOVE  = 1;
	localparam int FLAG_T_HIGH = 2;
	localparam int FLAG_T_LOW  = 3;
	localparam int FLAG_H_HIGH = 4;
	localparam int FLAG_H_LOW  = 5;

	typedef enum logic [1:0] {
		REG_WIRE_DROP,
		REG_SUPPLY,
		REG_LOAD,
		REG_R0
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RK_DIVIDE,
		RK_SAT,
		RK_ZERO
	} ratio_kind_t;

	typedef struct packed {
		logic [12:0]       load_voltage_mv;
		logic signed [7:0] temperature_c;
		logic [7:0]        humidity_pct;
	} sample_t;

	typedef struct packed {
		logic [PPM_W-1:0]  concentration_ppm;
		logic [FLAG_W-1:0] range_flags;
	} result_t;

	typedef struct packed {
		logic [N2_W-1:0]   num;
		logic [D_W-1:0]    den;
		ratio_kind_t       kind;
		logic [FLAG_W-1:0] flags;
	} comp_out_t;

	typedef struct packed {
		logic [QUO_W-1:0]  quo;
		ratio_kind_t       kind;
		logic [FLAG_W-1:0] flags;
	} quot_t;

	localparam logic signed [7:0] TEMP_AXIS [TEMP_POINTS] = '{-10, 0, 10, 20, 30, 40};
	localparam logic [7:0] HUMI_AXIS [HUMI_POINTS] = '{0, 20, 40, 65, 100};

	localparam logic [RATIO_W-1:0] COMP_TABLE [HUMI_POINTS][TEMP_POINTS] = '{
		'{122552, 117309, 114033, 110100, 108134, 105513},
		'{113377,  99615,  88474,  79299,  73400,  70124},
		'{110100,  95027,  81920,  72090,  64225,  60293},
		'{105513,  88474,  75366,  65536,  58982,  56361},
		'{101581,  85197,  72090,  62915,  56361,  54395}
	};

	localparam logic [PPM_W-1:0] CURVE_PPM [CURVE_POINTS] = '{
		500, 600, 700, 800, 900, 1000, 1300, 1700, 2000, 2100,
		3000, 4000, 4400, 5000, 6000, 7000, 8000, 9000, 10000
	};

	localparam logic [QUO_W-1:0] CURVE_RATIO [CURVE_POINTS] = '{
		98304, 91750, 85197, 78643, 72090, 65536, 58982, 52429, 47841, 45875,
		39322, 34734, 32768, 30802, 28180, 26870, 24904, 23593, 22938
	};

	localparam logic [63:0] RSCALE = 64'd1 << RSHIFT;

	// half the blend denominator per humidity cell (temperature span 10 times humidity span), for rounding
	localparam logic [7:0] DEN_HALF [HUMI_POINTS-1] = '{100, 100, 125, 175};

	localparam logic [DEN_RECIP_W-1:0] DEN_RECIP [HUMI_POINTS-1] = '{
		DEN_RECIP_W'((RSCALE + 64'd199) / 64'd200),
		DEN_RECIP_W'((RSCALE + 64'd199) / 64'd200),
		DEN_RECIP_W'((RSCALE + 64'd249) / 64'd250),
		DEN_RECIP_W'((RSCALE + 64'd349) / 64'd350)
	};

	// ceil(2^36 / span) for each curve segment
	localparam logic [SPAN_RECIP_W-1:0] SPAN_RECIP [CURVE_POINTS-1] = '{
		SPAN_RECIP_W'((RSCALE + 64'd6553) / 64'd6554),
		SPAN_RECIP_W'((RSCALE + 64'd6552) / 64'd6553),
		SPAN_RECIP_W'((RSCALE + 64'd6553) / 64'd6554),
		SPAN_RECIP_W'((RSCALE + 64'd6552) / 64'd6553),
		SPAN_RECIP_W'((RSCALE + 64'd6553) / 64'd6554),
		SPAN_RECIP_W'((RSCALE + 64'd6553) / 64'd6554),
		SPAN_RECIP_W'((RSCALE + 64'd6552) / 64'd6553),
		SPAN_RECIP_W'((RSCALE + 64'd4587) / 64'd4588),
		SPAN_RECIP_W'((RSCALE + 64'd1965) / 64'd1966),
		SPAN_RECIP_W'((RSCALE + 64'd6552) / 64'd6553),
		SPAN_RECIP_W'((RSCALE + 64'd4587) / 64'd4588),
		SPAN_RECIP_W'((RSCALE + 64'd1965) / 64'd1966),
		SPAN_RECIP_W'((RSCALE + 64'd1965) / 64'd1966),
		SPAN_RECIP_W'((RSCALE + 64'd2621) / 64'd2622),
		SPAN_RECIP_W'((RSCALE + 64'd1309) / 64'd1310),
		SPAN_RECIP_W'((RSCALE + 64'd1965) / 64'd1966),
		SPAN_RECIP_W'((RSCALE + 64'd1310) / 64'd1311),
		SPAN_RECIP_W'((RSCALE + 64'd654) / 64'd655)
	};

endpackage

>>> src/gspl_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspl_comp: compensation and ratio operand stages
// Clamps temperature and humidity, blends the compensation table, and forms
// the numerator and denominator of the measured Rs/R0 ratio.
// ----------------------------------------------------------------------------
module gspl_comp
	import gspl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  sample_t           sample,
	input  logic [9:0]        wire_drop_mv,
	input  logic [12:0]       supply_mv,
	input  logic [19:0]       load_ohms,
	input  logic [19:0]       standard_r0_ohms,
	output logic              out_valid,
	output comp_out_t         job
);

	logic signed [7:0]      t_c;
	logic [7:0]             h_c;
	logic [TEMP_POINTS-1:0] t_gt;
	logic [HUMI_POINTS-1:0] h_gt;
	logic [TI_W-1:0]        ti;
	logic [HI_W-1:0]        hi;
	logic signed [8:0]      dt0, dt1;
	logic [7:0]             dh0, dh1;
	logic [FLAG_W-1:0]      flags_c;

	always_comb begin
		t_c = sample.temperature_c;
		h_c = sample.humidity_pct;
		flags_c = '0;
		if (sample.temperature_c > TEMP_AXIS[TEMP_POINTS-1]) begin
			t_c = TEMP_AXIS[TEMP_POINTS-1];
			flags_c[FLAG_T_HIGH] = 1'b1;
		end else if (sample.temperature_c < TEMP_AXIS[0]) begin
			t_c = TEMP_AXIS[0];
			flags_c[FLAG_T_LOW] = 1'b1;
		end
		if (sample.humidity_pct > HUMI_AXIS[HUMI_POINTS-1]) begin
			h_c = HUMI_AXIS[HUMI_POINTS-1];
			flags_c[FLAG_H_HIGH] = 1'b1;
		end else if (sample.humidity_pct < HUMI_AXIS[0]) begin
			h_c = HUMI_AXIS[0];
			flags_c[FLAG_H_LOW] = 1'b1;
		end
		t_gt = '0;
		for (int k = 1; k < TEMP_POINTS - 1; k++)
			t_gt[k] = t_c > TEMP_AXIS[k];
		h_gt = '0;
		for (int k = 1; k < HUMI_POINTS - 1; k++)
			h_gt[k] = h_c > HUMI_AXIS[k];
		ti = TI_W'($countones(t_gt));
		hi = HI_W'($countones(h_gt));
		dt1 = 9'(t_c) - 9'(TEMP_AXIS[ti]);
		dt0 = 9'(TEMP_AXIS[TI_W'(ti + 1'b1)]) - 9'(t_c);
		dh1 = h_c - HUMI_AXIS[hi];
		dh0 = HUMI_AXIS[HI_W'(hi + 1'b1)] - h_c;
	end

	// stage 1
	logic                valid_s1;
	logic [VOLT_W-1:0]   v_s1;
	logic [FLAG_W-1:0]   flags_s1;
	logic [HI_W-1:0]     hi_s1;
	logic [TW_W-1:0]     wt0_s1, wt1_s1;
	logic [HW_W-1:0]     wh0_s1, wh1_s1;
	logic [RATIO_W-1:0]  c00_s1, c01_s1, c10_s1, c11_s1;

	// stage 2
	logic                valid_s2;
	logic [A_W-1:0]      a_s2, b_s2;
	logic [HW_W-1:0]     wh0_s2, wh1_s2;
	logic [HI_W-1:0]     hi_s2;
	logic [VR_W-1:0]     vr_s2;
	logic [N_W-1:0]      n_s2;
	ratio_kind_t         kind_s2;
	logic [FLAG_W-1:0]   flags_s2;

	// stage 3
	logic                valid_s3;
	logic [NUM_W-1:0]    num_s3;
	logic [HI_W-1:0]     hi_s3;
	logic [VR_W-1:0]     vr_s3;
	logic [N_W-1:0]      n_s3;
	ratio_kind_t         kind_s3;
	logic [FLAG_W-1:0]   flags_s3;

	// stage 4
	logic                valid_s4;
	logic [RATIO_W-1:0]  ratio0_s4;
	logic [VR_W-1:0]     vr_s4;
	logic [N_W-1:0]      n_s4;
	ratio_kind_t         kind_s4;
	logic [FLAG_W-1:0]   flags_s4;

	// stage 5
	logic                valid_s5;
	comp_out_t           job_s5;

	ratio_kind_t         kind_c;
	logic [DP_W-1:0]     prod_c;

	always_comb begin
		if (v_s1 == '0 || standard_r0_ohms == '0)
			kind_c = RK_SAT;
		else if (v_s1 >= VOLT_W'(supply_mv))
			kind_c = RK_ZERO;
		else
			kind_c = RK_DIVIDE;
		prod_c = DP_W'(num_s3) * DP_W'(DEN_RECIP[hi_s3[HC_W-1:0]]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1     <= VOLT_W'(sample.load_voltage_mv) + VOLT_W'(wire_drop_mv);
			flags_s1 <= flags_c;
			hi_s1    <= hi;
			wt0_s1   <= dt0[TW_W-1:0];
			wt1_s1   <= dt1[TW_W-1:0];
			wh0_s1   <= dh0[HW_W-1:0];
			wh1_s1   <= dh1[HW_W-1:0];
			c00_s1   <= COMP_TABLE[hi][ti];
			c01_s1   <= COMP_TABLE[hi][TI_W'(ti + 1'b1)];
			c10_s1   <= COMP_TABLE[HI_W'(hi + 1'b1)][ti];
			c11_s1   <= COMP_TABLE[HI_W'(hi + 1'b1)][TI_W'(ti + 1'b1)];

			a_s2     <= A_W'(wt0_s1) * A_W'(c00_s1) + A_W'(wt1_s1) * A_W'(c01_s1);
			b_s2     <= A_W'(wt0_s1) * A_W'(c10_s1) + A_W'(wt1_s1) * A_W'(c11_s1);
			wh0_s2   <= wh0_s1;
			wh1_s2   <= wh1_s1;
			hi_s2    <= hi_s1;
			vr_s2    <= VR_W'(v_s1) * VR_W'(standard_r0_ohms);
			n_s2     <= N_W'(VOLT_W'(supply_mv) - v_s1) * N_W'(load_ohms);
			kind_s2  <= kind_c;
			flags_s2 <= flags_s1;

			num_s3   <= NUM_W'(wh0_s2) * NUM_W'(a_s2) + NUM_W'(wh1_s2) * NUM_W'(b_s2)
				+ NUM_W'(DEN_HALF[hi_s2[HC_W-1:0]]);
			hi_s3    <= hi_s2;
			vr_s3    <= vr_s2;
			n_s3     <= n_s2;
			kind_s3  <= kind_s2;
			flags_s3 <= flags_s2;

			ratio0_s4 <= prod_c[RSHIFT +: RATIO_W];
			vr_s4     <= vr_s3;
			n_s4      <= n_s3;
			kind_s4   <= kind_s3;
			flags_s4  <= flags_s3;

			job_s5.num   <= {n_s4, {QPRE{1'b0}}};
			job_s5.den   <= D_W'(vr_s4) * D_W'(ratio0_s4);
			job_s5.kind  <= kind_s4;
			job_s5.flags <= flags_s4;
		end
	end

	assign out_valid = valid_s5;
	assign job       = job_s5;

endmodule

>>> src/gspl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspl_div: pipelined restoring divider for the measured ratio
// One setup stage screens saturation, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module gspl_div
	import gspl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  comp_out_t job,
	output logic      out_valid,
	output quot_t     quo
);

	logic [QUO_W:0]    valid_s;
	logic [D_W-1:0]    rem_s   [QUO_W+1];
	logic [D_W-1:0]    den_s   [QUO_W+1];
	logic [QUO_W-1:0]  quo_s   [QUO_W+1];
	ratio_kind_t       kind_s  [QUO_W+1];
	logic [FLAG_W-1:0] flags_s [QUO_W+1];

	logic [D_W-1:0]    rem_nx  [QUO_W+1];
	logic [QUO_W:0]    bit_nx;
	logic [D_W:0]      sh, diff;
	ratio_kind_t       kind_c;

	always_comb begin
		kind_c = job.kind;
		if (job.kind == RK_DIVIDE && (job.den == '0 || D_W'(job.num) >= job.den))
			kind_c = RK_SAT;
		rem_nx[0] = '0;
		bit_nx = '0;
		sh = '0;
		diff = '0;
		for (int i = 1; i <= QUO_W; i++) begin
			sh   = {rem_s[i-1], 1'b0};
			diff = sh - {1'b0, den_s[i-1]};
			bit_nx[i] = sh >= {1'b0, den_s[i-1]};
			rem_nx[i] = bit_nx[i] ? diff[D_W-1:0] : sh[D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[QUO_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= D_W'(job.num);
			den_s[0]   <= job.den;
			quo_s[0]   <= '0;
			kind_s[0]  <= kind_c;
			flags_s[0] <= job.flags;
			for (int i = 1; i <= QUO_W; i++) begin
				rem_s[i]   <= rem_nx[i];
				den_s[i]   <= den_s[i-1];
				quo_s[i]   <= {quo_s[i-1][QUO_W-2:0], bit_nx[i]};
				kind_s[i]  <= kind_s[i-1];
				flags_s[i] <= flags_s[i-1];
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign quo.quo   = quo_s[QUO_W];
	assign quo.kind  = kind_s[QUO_W];
	assign quo.flags = flags_s[QUO_W];

endmodule

>>> src/gspl_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspl_curve: ratio to ppm through the piecewise-linear curve
// Segment search by parallel compares, slope product, reciprocal scaling;
// the last stage is the result register.
// ----------------------------------------------------------------------------
module gspl_curve
	import gspl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  quot_t   quo,
	output logic    out_valid,
	output result_t result
);

	logic [QUO_W-1:0]        r_c;
	logic [CURVE_POINTS-1:0] le_c;
	logic [FLAG_W-1:0]       flags_c;

	always_comb begin
		case (quo.kind)
			RK_SAT:  r_c = '1;
			RK_ZERO: r_c = '0;
			default: r_c = quo.quo;
		endcase
		le_c = '0;
		for (int j = 1; j < CURVE_POINTS - 1; j++)
			le_c[j] = r_c <= CURVE_RATIO[j];
		flags_c = quo.flags;
		flags_c[FLAG_BELOW] = r_c > CURVE_RATIO[0];
		flags_c[FLAG_ABOVE] = r_c < CURVE_RATIO[CURVE_POINTS-1];
	end

	logic              valid_s1, valid_s2, valid_s3;
	logic [QUO_W-1:0]  r_s1;
	logic [CK_W-1:0]   k_s1, k_s2;
	logic              below_s1, below_s2;
	logic              top_s1, top_s2;
	logic [FLAG_W-1:0] flags_s1, flags_s2;
	logic [X_W-1:0]    x_s2;
	result_t           result_s3;

	logic [QUO_W-1:0]  diff_c;
	logic [PPM_W-1:0]  dx_c;
	logic [SP_W-1:0]   prod_c;

	always_comb begin
		diff_c = CURVE_RATIO[k_s1] - r_s1;
		dx_c   = CURVE_PPM[CK_W'(k_s1 + 1'b1)] - CURVE_PPM[k_s1];
		prod_c = SP_W'(x_s2) * SP_W'(SPAN_RECIP[k_s2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= r_c;
			k_s1     <= CK_W'($countones(le_c));
			below_s1 <= r_c > CURVE_RATIO[0];
			top_s1   <= r_c <= CURVE_RATIO[CURVE_POINTS-1];
			flags_s1 <= flags_c;

			x_s2     <= X_W'(dx_c) * X_W'(diff_c[SPAN_W-1:0]);
			k_s2     <= k_s1;
			below_s2 <= below_s1;
			top_s2   <= top_s1;
			flags_s2 <= flags_s1;

			result_s3.range_flags <= flags_s2;
			if (below_s2)
				result_s3.concentration_ppm <= '0;
			else if (top_s2)
				result_s3.concentration_ppm <= CURVE_PPM[CURVE_POINTS-1];
			else
				result_s3.concentration_ppm <= CURVE_PPM[k_s2] + prod_c[RSHIFT +: PPM_W];
		end
	end

	assign out_valid = valid_s3;
	assign result    = result_s3;

endmodule

>>> src/gas_sensor_ppm_linearizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer_unit: methane ppm from sensor load voltage
// Input beats (sample) carry load voltage, temperature and humidity; output
// beats (result) carry ppm and range flags, one result per input, in order.
// Both channels are valid/stall; a beat moves when valid is high and stall
// is low. Configuration registers are written on the cfg channel (index,
// data) whenever cfg_valid and cfg_ready are high; cfg_ready is always high.
// Registers should only change while no beat is in flight.
// An accepted sample passes through five compensation stages, a setup stage
// and twenty one-bit divider stages, and three curve stages ending in the
// result register. Throughput is one beat per cycle unless a stalled result
// holds the pipeline; the divider stage chain sets the depth.
// A stalled result freezes the whole pipeline, so sample_stall follows
// result_stall while a result is held; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults: wire drop 0,
// supply 5000 mV, load 10000 ohms, R0 10000 ohms.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer_unit
	import gspl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	logic [9:0]  wire_drop_q;
	logic [12:0] supply_q;
	logic [19:0] load_q;
	logic [19:0] r0_q;

	logic        en;
	logic        comp_valid, div_valid;
	comp_out_t   job;
	quot_t       quo;

	assign cfg_ready    = 1'b1;
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_drop_q <= 10'd0;
			supply_q    <= 13'd5000;
			load_q      <= 20'd10000;
			r0_q        <= 20'd10000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIRE_DROP: wire_drop_q <= cfg_data[9:0];
				REG_SUPPLY:    supply_q    <= cfg_data[12:0];
				REG_LOAD:      load_q      <= cfg_data;
				REG_R0:        r0_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	gspl_comp u_comp (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (sample_valid),
		.sample           (sample),
		.wire_drop_mv     (wire_drop_q),
		.supply_mv        (supply_q),
		.load_ohms        (load_q),
		.standard_r0_ohms (r0_q),
		.out_valid        (comp_valid),
		.job              (job)
	);

	gspl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (comp_valid),
		.job       (job),
		.out_valid (div_valid),
		.quo       (quo)
	);

	gspl_curve u_curve (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.quo       (quo),
		.out_valid (result_valid),
		.result    (result)
	);

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: gas sensor ppm linearizer testbench
// Drives sample beats with random idling on both sides and a long result
// hold-off. Each result beat is checked against a fixed value (known rows)
// or an in-bench model of the compensation blend, resistance ratio and ppm
// curve. Register settings are changed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;
	import gspl_pkg::*;

	localparam int LATENCY = 29;
	localparam int LIMIT   = 400000;

	typedef struct {
		logic [12:0] v;
		int          t;
		int          h;
		bit          known;
		result_t     res;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        sample_valid = 0;
	logic        sample_stall;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_stall = 0;
	result_t     result;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	result_t     ppm_queue[$];
	int          fails = 0;
	int          cycles = 0;
	bit          quiet = 0;
	bit          hold_req = 0;
	int unsigned wire_drop, supply, load_r, r0;

	gas_sensor_ppm_linearizer_unit i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int cell_of(int v, int ax[], int n);
		for (int k = 0; k + 2 < n; k++)
			if (v <= ax[k + 1]) return k;
		return n - 2;
	endfunction

	function automatic result_t predict_ppm(logic [12:0] vin, int t, int h);
		int tax[] = '{-10, 0, 10, 20, 30, 40};
		int hax[] = '{0, 20, 40, 65, 100};
		int ti, hi, k;
		longint unsigned wt0, wt1, wh0, wh1, num, den, n, d, rem, q, ratio0;
		longint unsigned v, r;
		logic [5:0] fl;
		result_t o;
		fl = 0;
		if (t > 40) begin t = 40; fl[FLAG_T_HIGH] = 1; end
		else if (t < -10) begin t = -10; fl[FLAG_T_LOW] = 1; end
		if (h > 100) begin h = 100; fl[FLAG_H_HIGH] = 1; end
		ti = cell_of(t, tax, 6);
		hi = cell_of(h, hax, 5);
		wt1 = t - tax[ti]; wt0 = tax[ti + 1] - t;
		wh1 = h - hax[hi]; wh0 = hax[hi + 1] - h;
		num = wh0 * (wt0 * COMP_TABLE[hi][ti] + wt1 * COMP_TABLE[hi][ti + 1])
			+ wh1 * (wt0 * COMP_TABLE[hi + 1][ti] + wt1 * COMP_TABLE[hi + 1][ti + 1]);
		den = (wt0 + wt1) * (wh0 + wh1);
		ratio0 = (num + den / 2) / den;
		v = vin + wire_drop;
		if (v == 0 || r0 == 0) r = 64'hFFFFF;
		else if (v >= supply) r = 0;
		else begin
			n = (supply - v) * load_r;
			d = v * r0 * ratio0;
			if (d == 0 || (n << 12) >= d) r = 64'hFFFFF;
			else begin
				rem = n; q = 0;
				for (int b = 0; b < 32; b++) begin
					rem = rem << 1; q = q << 1;
					if (rem >= d) begin rem -= d; q |= 1; end
				end
				r = q[31:0];
			end
		end
		if (r > CURVE_RATIO[0]) begin
			fl[FLAG_BELOW] = 1; o.concentration_ppm = 0;
		end else if (r <= CURVE_RATIO[CURVE_POINTS - 1]) begin
			if (r < CURVE_RATIO[CURVE_POINTS - 1]) fl[FLAG_ABOVE] = 1;
			o.concentration_ppm = CURVE_PPM[CURVE_POINTS - 1];
		end else begin
			for (k = 0; k + 2 < CURVE_POINTS; k++)
				if (r > CURVE_RATIO[k + 1]) break;
			o.concentration_ppm = CURVE_PPM[k] + ((CURVE_PPM[k + 1] - CURVE_PPM[k])
				* (CURVE_RATIO[k] - r)) / (CURVE_RATIO[k] - CURVE_RATIO[k + 1]);
		end
		o.range_flags = fl;
		return o;
	endfunction

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= 20'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_WIRE_DROP: wire_drop = val;
			REG_SUPPLY:    supply = val;
			REG_LOAD:      load_r = val;
			default:       r0 = val;
		endcase
	endtask

	task automatic drain;
		sample_valid <= 0;
		while (ppm_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send(logic [12:0] v, int t, int h, bit known, result_t res);
		while (!quiet && $urandom_range(99) < 21) begin
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 1;
		sample.load_voltage_mv <= v;
		sample.temperature_c <= t[7:0];
		sample.humidity_pct <= h[7:0];
		ppm_queue.push_back(known ? res : predict_ppm(v, $signed(t[7:0]), h[7:0]));
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	task automatic send_back_to_back(int count);
		for (int i = 0; i < count; i++) begin
			sample_valid <= 1;
			sample.load_voltage_mv <= 13'($urandom_range(8191));
			sample.temperature_c <= 8'($urandom);
			sample.humidity_pct <= 8'($urandom);
			#1;
			ppm_queue.push_back(predict_ppm(sample.load_voltage_mv,
				$signed(sample.temperature_c), sample.humidity_pct));
			@(posedge clk);
			while (sample_stall) @(posedge clk);
		end
		sample_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (ppm_queue.size() == 0) begin
				$display("%0t unexpected result %p", $realtime, result);
				fails++;
			end else begin
				if (result.concentration_ppm !== ppm_queue[0].concentration_ppm)
					begin
					$display("%0t ppm exp %0d got %0d", $realtime,
						ppm_queue[0].concentration_ppm, result.concentration_ppm);
					fails++;
				end
				if (result.range_flags !== ppm_queue[0].range_flags) begin
					$display("%0t flags exp %b got %b", $realtime,
						ppm_queue[0].range_flags, result.range_flags);
					fails++;
				end
				void'(ppm_queue.pop_front());
			end
		end
	end

	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1;
				hold = 0;
				while (hold < 80) begin @(posedge clk); hold++; end
				hold_req = 0;
				result_stall <= 0;
			end else
				result_stall <= !quiet && ($urandom_range(99) < 21);
		end
	end

	initial begin
		row_t rows[$];
		result_t sat0, sat1;
		int unsigned settings[5][4];
		sat0.concentration_ppm = 0;     sat0.range_flags = 6'b000001;
		sat1.concentration_ppm = 10000; sat1.range_flags = 6'b000010;
		wire_drop = 0; supply = 5000; load_r = 10000; r0 = 10000;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		rows.push_back('{13'd0, 20, 50, 1, sat0});
		rows.push_back('{13'd5000, 20, 50, 1, sat1});
		rows.push_back('{13'd8191, 25, 65, 1, sat1});
		rows.push_back('{13'd0, -128, 255, 1, '{0, 6'b011001}});
		rows.push_back('{13'd0, 127, 0, 1, '{0, 6'b000101}});
		rows.push_back('{13'd5000, -11, 101, 1, '{10000, 6'b011010}});
		rows.push_back('{13'd2500, 20, 65, 0, '0});
		rows.push_back('{13'd2500, -10, 0, 0, '0});
		rows.push_back('{13'd2500, 40, 100, 0, '0});
		rows.push_back('{13'd1, 0, 20, 0, '0});
		rows.push_back('{13'd4999, 10, 40, 0, '0});
		rows.push_back('{13'd3000, 30, 65, 0, '0});
		rows.push_back('{13'd1800, 15, 30, 0, '0});
		rows.push_back('{13'd3700, 41, 200, 0, '0});
		rows.push_back('{13'd2200, -50, 10, 0, '0});
		foreach (rows[i]) send(rows[i].v, rows[i].t, rows[i].h, rows[i].known, rows[i].res);
		drain();

		settings = '{'{0, 5000, 10000, 10000}, '{1000, 5000, 1000000, 1},
			'{0, 1, 1, 1000000}, '{500, 3300, 47000, 20000}, '{1023, 8191, 1048575, 1048575}};
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_WIRE_DROP, settings[p][0]);
			write_reg(REG_SUPPLY, settings[p][1]);
			write_reg(REG_LOAD, settings[p][2]);
			write_reg(REG_R0, settings[p][3]);
			if (p == 1) begin
				hold_req = 1;
				send_back_to_back(60);
			end
			for (int i = 0; i < 225; i++)
				send($urandom_range(99) < 10 ? $urandom_range(8191) : $urandom_range(5000),
					$urandom_range(99) < 20 ? $signed(8'($urandom)) : $urandom_range(50) - 10,
					$urandom_range(99) < 20 ? $urandom_range(255) : $urandom_range(100),
					0, '0);
			if (p == 2) begin
				quiet = 1;
				send_back_to_back(100);
				quiet = 0;
			end
			drain();
		end
		if (fails == 0 && ppm_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
